// ----- sv/sfb_pkg.sv -----
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared codes, types and the byte stuffing helper of the stuffed frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

  // Input request operations
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_FLAG    = 3'd0;
  localparam logic [2:0] REG_ADDRESS = 3'd1;
  localparam logic [2:0] REG_SPEC_A  = 3'd2;
  localparam logic [2:0] REG_SPEC_B  = 3'd3;
  localparam logic [2:0] REG_ESCAPE  = 3'd4;
  localparam logic [2:0] REG_SUBST_A = 3'd5;
  localparam logic [2:0] REG_SUBST_B = 3'd6;

  localparam int unsigned BURST_MAX = 4;

  typedef logic [7:0] byte_t;

  // Escape settings as seen by the stuffing logic
  typedef struct packed {
    byte_t spec_a;
    byte_t spec_b;
    byte_t escape;
    byte_t subst_a;
    byte_t subst_b;
  } stuff_cfg_t;

  // One stuffed byte: either the byte itself or an escape pair
  typedef struct packed {
    logic  pair;
    byte_t first;
    byte_t second;
  } stuffed_t;

  function automatic stuffed_t stuff_byte(input byte_t b, input stuff_cfg_t c);
    stuffed_t s;
    s.pair   = 1'b0;
    s.first  = b;
    s.second = b;
    if (b == c.spec_a) begin
      s.pair   = 1'b1;
      s.first  = c.escape;
      s.second = c.subst_a;
    end else if (b == c.spec_b) begin
      s.pair   = 1'b1;
      s.first  = c.escape;
      s.second = c.subst_b;
    end
    return s;
  endfunction

endpackage

// ----- sv/stuffed_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// stuffed_frame_builder_unit
// Byte-stuffing frame builder with an XOR block check byte.
// ----------------------------------------------------------------------------
// Each accepted request other than opcode three becomes a burst of one to four
// line bytes held in a small burst register, which then drains one byte per
// cycle on the result channel while out_ready is high. A start request gives
// four bytes (flag, address, control, address XOR control), a data request one
// byte or an escape pair of two, and an end request the stuffed check byte and
// the closing flag (two or three bytes). The result port's drain sets the
// pace: plain data streams at one request per cycle while out_ready is high,
// and an escaped byte holds off the next request until both bytes of its pair
// are taken. The next request is taken in the same cycle as the last byte of
// the current burst is taken, so there is no gap between bursts. Request
// opcode three is accepted and dropped. Configuration writes are always
// accepted; write them only while the block is idle.
// ----------------------------------------------------------------------------
module stuffed_frame_builder_unit (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  sfb_pkg::byte_t      in_value,
  // line byte channel
  output logic                out_valid,
  input  logic                out_ready,
  output sfb_pkg::byte_t      out_line_byte,
  output logic                out_last_of_run,
  output logic                out_frame_done,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  sfb_pkg::byte_t      cfg_data
);
  import sfb_pkg::*;

  localparam int unsigned IdxW = $clog2(BURST_MAX);
  localparam int unsigned CntW = $clog2(BURST_MAX + 1);

  // Configuration registers
  byte_t flag_r, address_r, spec_a_r, spec_b_r, escape_r, subst_a_r, subst_b_r;
  // Running XOR of payload bytes since the last start
  byte_t check_r, check_nxt;

  // Burst register: bytes of the current request and its drain position
  byte_t                burst_r   [BURST_MAX];
  byte_t                burst_nxt [BURST_MAX];
  logic [CntW-1:0]      count_r, count_nxt;
  logic [IdxW-1:0]      idx_r, idx_nxt;
  logic                 end_r, end_nxt;

  logic                 in_take;
  logic                 out_take;
  logic                 at_last;
  logic                 load;
  stuff_cfg_t           scfg;
  stuffed_t             st_data;
  stuffed_t             st_check;
  logic [CntW-1:0]      next_pos;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r    <= 8'd126;
      address_r <= 8'd3;
      spec_a_r  <= 8'd126;
      spec_b_r  <= 8'd125;
      escape_r  <= 8'd125;
      subst_a_r <= 8'd94;
      subst_b_r <= 8'd93;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FLAG:    flag_r    <= cfg_data;
        REG_ADDRESS: address_r <= cfg_data;
        REG_SPEC_A:  spec_a_r  <= cfg_data;
        REG_SPEC_B:  spec_b_r  <= cfg_data;
        REG_ESCAPE:  escape_r  <= cfg_data;
        REG_SUBST_A: subst_a_r <= cfg_data;
        REG_SUBST_B: subst_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Drain control: the burst is empty when count is zero
  assign next_pos  = CntW'(idx_r) + CntW'(1);
  assign at_last   = (count_r != '0) && (next_pos == count_r);
  assign out_valid = (count_r != '0);
  assign out_take  = out_valid && out_ready;
  // Take a new request when empty or when the last byte leaves this cycle
  assign in_ready  = !out_valid || (at_last && out_ready);
  assign in_take   = in_valid && in_ready;
  assign load      = in_take && (in_opcode != OP_NONE);

  assign out_line_byte   = burst_r[idx_r];
  assign out_last_of_run = at_last;
  assign out_frame_done  = at_last && end_r;

  assign scfg.spec_a  = spec_a_r;
  assign scfg.spec_b  = spec_b_r;
  assign scfg.escape  = escape_r;
  assign scfg.subst_a = subst_a_r;
  assign scfg.subst_b = subst_b_r;

  assign st_data  = stuff_byte(in_value, scfg);
  assign st_check = stuff_byte(check_r, scfg);

  // Advance the current burst and build the burst for the incoming request
  always_comb begin
    for (int i = 0; i < BURST_MAX; i++) begin
      burst_nxt[i] = burst_r[i];
    end
    count_nxt = count_r;
    idx_nxt   = idx_r;
    end_nxt   = end_r;
    check_nxt = check_r;

    // advance or retire the current burst
    if (out_take) begin
      if (at_last) begin
        count_nxt = '0;
        idx_nxt   = '0;
      end else begin
        idx_nxt = next_pos[IdxW-1:0];
      end
    end

    if (load) begin
      idx_nxt = '0;
      unique case (in_opcode)
        OP_START: begin
          burst_nxt[0] = flag_r;
          burst_nxt[1] = address_r;
          burst_nxt[2] = in_value;
          burst_nxt[3] = address_r ^ in_value;
          count_nxt    = CntW'(4);
          end_nxt      = 1'b0;
          check_nxt    = '0;
        end
        OP_DATA: begin
          burst_nxt[0] = st_data.first;
          burst_nxt[1] = st_data.second;
          count_nxt    = st_data.pair ? CntW'(2) : CntW'(1);
          end_nxt      = 1'b0;
          check_nxt    = check_r ^ in_value;
        end
        OP_END: begin
          burst_nxt[0] = st_check.first;
          burst_nxt[1] = st_check.pair ? st_check.second : flag_r;
          burst_nxt[2] = flag_r;
          count_nxt    = st_check.pair ? CntW'(3) : CntW'(2);
          end_nxt      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      end_r   <= 1'b0;
      check_r <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
      check_r <= check_nxt;
    end
  end

  // Burst bytes are payload: no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < BURST_MAX; i++) begin
      burst_r[i] <= burst_nxt[i];
    end
  end

endmodule

// ----- sv/sfb_checker.sv -----
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks on the stuffed frame builder, bound to its top level.
// ----------------------------------------------------------------------------
module sfb_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic [1:0]     in_opcode,
  input logic           out_valid,
  input logic           out_ready,
  input logic [7:0]     out_line_byte,
  input logic           out_last_of_run,
  input logic           out_frame_done
);
  import sfb_pkg::*;

  // Reset leaves no byte pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("line byte pending after reset");

  // The closing flag always ends its request's run
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame_done without last_of_run");

  // A taken request other than the dropped code yields at least one byte
  a_request_yields: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_NONE) |=> out_valid)
    else $error("accepted request produced no line byte");

  // A stalled line byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_byte)
      && $stable(out_last_of_run) && $stable(out_frame_done))
    else $error("stalled line byte changed");

endmodule

bind stuffed_frame_builder_unit sfb_checker u_sfb_checker (.*);

// ----- sim/tb_stuffed_frame_builder_unit.sv -----
// ----------------------------------------------------------------------------
// tb_stuffed_frame_builder_unit
// Self-checking bench for the byte-stuffing frame builder with XOR check byte.
// ----------------------------------------------------------------------------
// Requests (start, data, end, and the dropped opcode) are driven over the
// valid/ready request channel. A scoreboard keeps its own copy of the
// registers and the running check byte and queues the line bytes each
// accepted request should yield. Every line byte taken from the block is
// compared field by field with the oldest queued byte. A directed opening
// covers the corner cases. Random framed traffic then runs under several
// register settings, extremes included, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_builder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sfb_pkg::*;

  // Index past the last register: writes to it must be dropped
  localparam logic [2:0] REG_UNUSED   = 3'd7;
  // Cycles to let the burst register settle once the queue is empty
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    byte_t line_byte;
    logic  last_of_run;
    logic  frame_done;
  } line_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the line bytes of each accepted request and checks
  // the bytes taken from the block against them, oldest first.
  // --------------------------------------------------------------------------
  class line_byte_scoreboard;
    // register copies, at their reset values
    byte_t flag_b  = 8'h7E;
    byte_t addr_b  = 8'h03;
    byte_t spec_a  = 8'h7E;
    byte_t spec_b  = 8'h7D;
    byte_t esc_b   = 8'h7D;
    byte_t subst_a = 8'h5E;
    byte_t subst_b = 8'h5D;
    // XOR of the raw payload bytes since the last start
    byte_t check_acc = 8'h00;
    line_rec_t   pending_bytes[$];
    int unsigned fail_count = 0;

    function void write_reg(input logic [2:0] idx, input byte_t d);
      case (idx)
        REG_FLAG:    flag_b  = d;
        REG_ADDRESS: addr_b  = d;
        REG_SPEC_A:  spec_a  = d;
        REG_SPEC_B:  spec_b  = d;
        REG_ESCAPE:  esc_b   = d;
        REG_SUBST_A: subst_a = d;
        REG_SUBST_B: subst_b = d;
        default: ;
      endcase
    endfunction

    function void push(input byte_t b, input logic last, input logic done);
      line_rec_t r;
      r.line_byte   = b;
      r.last_of_run = last;
      r.frame_done  = done;
      pending_bytes.push_back(r);
    endfunction

    // special_a wins when both specials hold the same value
    function void push_stuffed(input byte_t b, input logic last);
      if (b == spec_a) begin
        push(esc_b, 1'b0, 1'b0);
        push(subst_a, last, 1'b0);
      end else if (b == spec_b) begin
        push(esc_b, 1'b0, 1'b0);
        push(subst_b, last, 1'b0);
      end else begin
        push(b, last, 1'b0);
      end
    endfunction

    function void predict_request(input logic [1:0] op, input byte_t v);
      case (op)
        OP_START: begin
          // header goes out as it is, never stuffed
          push(flag_b, 1'b0, 1'b0);
          push(addr_b, 1'b0, 1'b0);
          push(v, 1'b0, 1'b0);
          push(addr_b ^ v, 1'b1, 1'b0);
          check_acc = 8'h00;
        end
        OP_DATA: begin
          check_acc = check_acc ^ v;
          push_stuffed(v, 1'b1);
        end
        OP_END: begin
          // an end leaves the check byte as it is
          push_stuffed(check_acc, 1'b0);
          push(flag_b, 1'b1, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_line(input byte_t b, input logic last, input logic done);
      line_rec_t want;
      if (pending_bytes.size() == 0) begin
        $error("line_byte %02h arrived with no byte outstanding", b);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (b !== want.line_byte) begin
          $error("line_byte: expected %02h, got %02h", want.line_byte, b);
          fail_count++;
        end
        if (last !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run, last);
          fail_count++;
        end
        if (done !== want.frame_done) begin
          $error("frame_done: expected %0b, got %0b", want.frame_done, done);
          fail_count++;
        end
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic [1:0] in_opcode = OP_NONE;
  byte_t in_value = 8'h00;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_line_byte;
  logic  out_last_of_run;
  logic  out_frame_done;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic [2:0] cfg_index = REG_FLAG;
  byte_t cfg_data = 8'h00;

  // idling switches for each side, changed only at clock edges
  logic  in_idle_en = 1'b1;
  logic  out_idle_en = 1'b1;

  line_byte_scoreboard sb;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  stuffed_frame_builder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_line_byte   (out_line_byte),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Stall the line side about a third of the time while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(out_idle_en && ($urandom_range(99) < 33));
    end
  end

  // Check every line byte taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_line(out_line_byte, out_last_of_run, out_frame_done);
    end
  end

  // Watchdog: give up well past the slowest correct run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_stuffed_frame_builder_unit NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Present one request and hold it until taken. Valid is left high on exit;
  // the next request, a gap or a drain lowers or replaces it in the same step.
  task automatic send_request(input logic [1:0] op, input byte_t v);
    while (in_idle_en && ($urandom_range(99) < 33)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    do @(posedge clk); while (!in_ready);
    sb.predict_request(op, v);
    if (op != OP_NONE) items_sent++;
  endtask

  // Drop valid and wait until every predicted byte has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input byte_t d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_registers(input byte_t fl, input byte_t ad, input byte_t sa,
                                input byte_t sbv, input byte_t es, input byte_t ua,
                                input byte_t ub);
    wait_idle();
    write_reg(REG_FLAG, fl);
    write_reg(REG_ADDRESS, ad);
    write_reg(REG_SPEC_A, sa);
    write_reg(REG_SPEC_B, sbv);
    write_reg(REG_ESCAPE, es);
    write_reg(REG_SUBST_A, ua);
    write_reg(REG_SUBST_B, ub);
  endtask

  // Bias payload towards the bytes that need escaping and the extremes
  function automatic byte_t pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return sb.spec_a;
    if (r < 30) return sb.spec_b;
    if (r < 35) return 8'h00;
    if (r < 40) return 8'hFF;
    return byte_t'($urandom_range(255));
  endfunction

  // One well-formed frame: mostly short, now and then a long one. The last
  // byte is sometimes chosen so that the check byte itself needs escaping.
  task automatic send_frame();
    int unsigned len;
    byte_t v;
    len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    send_request(OP_START, pick_byte());
    for (int unsigned i = 0; i < len; i++) begin
      if (i == len - 1 && $urandom_range(99) < 25) begin
        v = sb.check_acc ^ ($urandom_range(1) ? sb.spec_a : sb.spec_b);
      end else begin
        v = pick_byte();
      end
      send_request(OP_DATA, v);
    end
    send_request(OP_END, byte_t'($urandom_range(255)));
  endtask

  task automatic run_traffic(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        send_frame();
      end else begin
        // noise: any opcode, which also leaves frames open or ends them twice
        send_request(2'($urandom_range(3)), byte_t'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at reset settings.
    // Data and end before any start run on the reset check byte.
    send_request(OP_DATA, 8'h12);
    send_request(OP_END, 8'h00);
    send_request(OP_NONE, 8'hAA);
    // Header bytes are never stuffed, even when they hit a special value.
    send_request(OP_START, 8'hFF);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hFF);
    send_request(OP_DATA, 8'h7E);
    send_request(OP_DATA, 8'h7D);
    // Two ends in a row: the check byte survives an end.
    send_request(OP_END, 8'hFF);
    send_request(OP_END, 8'h00);
    // Check byte equal to the first special, then to the second.
    send_request(OP_START, 8'h7E);
    send_request(OP_DATA, 8'h7E);
    send_request(OP_END, 8'h55);
    // Address XOR control lands on a special and must still go out plain.
    send_request(OP_START, 8'h7D);
    send_request(OP_DATA, 8'h7D);
    send_request(OP_END, 8'h00);
    send_request(OP_NONE, 8'h55);
    // Substitute values themselves pass through unchanged.
    send_request(OP_START, 8'h5A);
    send_request(OP_DATA, 8'h5E);
    send_request(OP_DATA, 8'h5D);
    send_request(OP_END, 8'h00);

    run_traffic(100);

    // Low extremes; both specials equal, so substitute_a must win.
    load_registers(8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF);
    run_traffic(90);

    // High extremes with a long stretch without any idling on either side.
    load_registers(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    in_idle_en  <= 1'b0;
    out_idle_en <= 1'b0;
    run_traffic(90);
    in_idle_en  <= 1'b1;
    out_idle_en <= 1'b1;

    // Random settings; a write past the last register must change nothing.
    load_registers(byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                   byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                   byte_t'($urandom_range(255)), byte_t'($urandom_range(255)),
                   byte_t'($urandom_range(255)));
    write_reg(REG_UNUSED, byte_t'($urandom_range(255)));
    run_traffic(100);

    wait_idle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("tb_stuffed_frame_builder_unit OK");
    end else begin
      $display("tb_stuffed_frame_builder_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sfb_pkg.sv
sv/stuffed_frame_builder_unit.sv
sv/sfb_checker.sv
sim/tb_stuffed_frame_builder_unit.sv
